// ===== rtl/mlp_softmax_sgd_trainer_defines.svh =====
// ----------------------------------------------------------------------------
// mlp softmax sgd trainer assertion macros
// shared concurrent assertion forms for the trainer
// ----------------------------------------------------------------------------
`ifndef MLP_SOFTMAX_SGD_TRAINER_DEFINES_SVH
`define MLP_SOFTMAX_SGD_TRAINER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MSST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MSST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/msst_pkg.sv =====
// ----------------------------------------------------------------------------
// msst_pkg
// shared sizes, codes, command types and helpers of the perceptron trainer
// ----------------------------------------------------------------------------
`default_nettype none

package msst_pkg;

   localparam int INPUT_COUNT  = 12;
   localparam int HIDDEN_COUNT = 8;
   localparam int CLASS_COUNT  = 3;

   // flat weight store layout
   localparam int W1_BASE      = 0;
   localparam int B1_BASE      = HIDDEN_COUNT * INPUT_COUNT;
   localparam int W2_BASE      = B1_BASE + HIDDEN_COUNT;
   localparam int B2_BASE      = W2_BASE + CLASS_COUNT * HIDDEN_COUNT;
   localparam int WEIGHT_DEPTH = B2_BASE + CLASS_COUNT;
   localparam int ADDR_W       = $clog2(WEIGHT_DEPTH);

   localparam int WEIGHT_W = 16;
   localparam int LR_W     = 16;
   localparam int PROB_W   = 16;
   localparam int H_W      = 15;
   localparam int HACC_W   = 20;
   localparam int OACC_W   = 35;
   localparam int Z_W      = 24;
   localparam int T_W      = 26;
   localparam int E_W      = 17;
   localparam int SUM_W    = 18;
   localparam int NUM_W    = 34;
   localparam int Q_W      = 17;
   localparam int DZ_W     = 18;
   localparam int DACC_W   = 36;
   localparam int G_W      = 35;
   localparam int STEP_W   = 22;
   localparam int CLS_W    = 2;
   localparam int HID_W    = 3;
   localparam int INP_W    = 4;

   localparam logic [12:0] LOG2E_Q12 = 13'd5909;
   localparam logic [15:0] LR_RESET  = 16'd6554;

   typedef enum logic [1:0] {
      OP_INFER = 2'd0,
      OP_TRAIN = 2'd1,
      OP_WRITE = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      A_NOP     = 5'd0,
      A_HB      = 5'd1,
      A_HW      = 5'd2,
      A_HSTORE  = 5'd3,
      A_ZB      = 5'd4,
      A_ZW      = 5'd5,
      A_ZSTORE  = 5'd6,
      A_EXP1    = 5'd7,
      A_EXP2    = 5'd8,
      A_DSTART  = 5'd9,
      A_PSTORE  = 5'd10,
      A_OUT     = 5'd11,
      A_MISC    = 5'd12,
      A_DZ      = 5'd13,
      A_DHCLR   = 5'd14,
      A_DHW     = 5'd15,
      A_DHSTORE = 5'd16,
      A_G       = 5'd17,
      A_B2W     = 5'd18,
      A_W2W     = 5'd19,
      A_S       = 5'd20,
      A_B1W     = 5'd21,
      A_W1W     = 5'd22
   } act_type;

   typedef struct packed {
      logic              load;
      act_type           act;
      logic [ADDR_W-1:0] addr;
      logic [CLS_W-1:0]  cls;
      logic [HID_W-1:0]  hid;
      logic [INP_W-1:0]  inp;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } stat_type;

   // 2^-(k/16) in q1.16
   function automatic logic [E_W-1:0] exp2_entry(input logic [4:0] k);
      logic [E_W-1:0] v;
      case (k)
         5'd0:    v = 17'd65536;
         5'd1:    v = 17'd62757;
         5'd2:    v = 17'd60097;
         5'd3:    v = 17'd57549;
         5'd4:    v = 17'd55109;
         5'd5:    v = 17'd52773;
         5'd6:    v = 17'd50535;
         5'd7:    v = 17'd48393;
         5'd8:    v = 17'd46341;
         5'd9:    v = 17'd44376;
         5'd10:   v = 17'd42495;
         5'd11:   v = 17'd40693;
         5'd12:   v = 17'd38968;
         5'd13:   v = 17'd37316;
         5'd14:   v = 17'd35734;
         5'd15:   v = 17'd34219;
         5'd16:   v = 17'd32768;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   function automatic logic [WEIGHT_W-1:0] sat16(input logic signed [23:0] v);
      logic [WEIGHT_W-1:0] r;
      if (v > 24'sd32767) begin
         r = 16'h7fff;
      end else if (v < -24'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/msst_wmem.sv =====
// ----------------------------------------------------------------------------
// msst_wmem
// flat weight and bias store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module msst_wmem (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [msst_pkg::ADDR_W-1:0]      waddr,
   input  wire logic [msst_pkg::WEIGHT_W-1:0]    wdata,
   input  wire logic [msst_pkg::ADDR_W-1:0]      raddr,
   output logic      [msst_pkg::WEIGHT_W-1:0]    rdata
);

   logic [msst_pkg::WEIGHT_W-1:0] mem [msst_pkg::WEIGHT_DEPTH];
   logic [msst_pkg::WEIGHT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[raddr];
   end

   assign rdata = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/msst_div.sv =====
// ----------------------------------------------------------------------------
// msst_div
// restoring divider, one quotient bit per cycle, quotient below 2^17
// ----------------------------------------------------------------------------
`default_nettype none

module msst_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [msst_pkg::NUM_W-1:0]    numer,
   input  wire logic [msst_pkg::SUM_W-1:0]    denom,
   output logic                               busy,
   output logic      [msst_pkg::Q_W-1:0]      quot
);

   localparam int QW = msst_pkg::Q_W;
   localparam int SW = msst_pkg::SUM_W;
   localparam int CW = $clog2(QW);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [QW-1:0] low_ff, low_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [SW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      trial   = {rem_ff, low_ff[QW-1]};
      if (start) begin
         // high part is already below the divisor
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = SW'(numer[msst_pkg::NUM_W-1:QW]);
         low_in  = numer[QW-1:0];
         quot_in = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, denom}) begin
            rem_in  = SW'(trial - {1'b0, denom});
            quot_in = {quot_ff[QW-2:0], 1'b1};
         end else begin
            rem_in  = trial[SW-1:0];
            quot_in = {quot_ff[QW-2:0], 1'b0};
         end
         low_in = {low_ff[QW-2:0], 1'b0};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(QW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

// ===== rtl/msst_ctrl.sv =====
// ----------------------------------------------------------------------------
// msst_ctrl
// sequencer: walks the forward pass, softmax and sgd update, one command a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module msst_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [1:0]         req_op,
   input  wire msst_pkg::stat_type stat,
   output logic                    busy,
   output msst_pkg::cmd_type       cmd
);

   localparam int AW = msst_pkg::ADDR_W;
   localparam int NI = msst_pkg::INPUT_COUNT;
   localparam int NH = msst_pkg::HIDDEN_COUNT;
   localparam int NC = msst_pkg::CLASS_COUNT;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_MISC   = 11'b000_0000_0010,
      ST_HID    = 11'b000_0000_0100,
      ST_OUT    = 11'b000_0000_1000,
      ST_EXP    = 11'b000_0001_0000,
      ST_DIV    = 11'b000_0010_0000,
      ST_RESULT = 11'b000_0100_0000,
      ST_DZ     = 11'b000_1000_0000,
      ST_DH     = 11'b001_0000_0000,
      ST_UPD2   = 11'b010_0000_0000,
      ST_UPD1   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in, next_state;
   logic [3:0] step_ff, step_in, step_end;
   logic [2:0] row_ff, row_in, row_end;
   logic       train_ff, train_in;
   logic       advance;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      row_in     = row_ff;
      train_in   = train_ff;
      next_state = ST_IDLE;
      step_end   = '0;
      row_end    = '0;
      advance    = 1'b0;
      cmd        = '0;
      cmd.act    = msst_pkg::A_NOP;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               train_in = (req_op == msst_pkg::OP_TRAIN);
               step_in  = '0;
               row_in   = '0;
               if (req_op inside {msst_pkg::OP_INFER, msst_pkg::OP_TRAIN}) begin
                  state_in = ST_HID;
               end else begin
                  state_in = ST_MISC;
               end
            end
         end
         ST_MISC: begin
            cmd.act  = msst_pkg::A_MISC;
            state_in = ST_IDLE;
         end
         ST_HID: begin
            // bias, one read per input, then clamp and store
            cmd.hid    = row_ff;
            step_end   = 4'(NI + 1);
            row_end    = 3'(NH - 1);
            next_state = ST_OUT;
            advance    = 1'b1;
            if (step_ff == 4'd0) begin
               cmd.act  = msst_pkg::A_HB;
               cmd.addr = AW'(msst_pkg::B1_BASE) + AW'(row_ff);
            end else if (step_ff <= 4'(NI)) begin
               cmd.act  = msst_pkg::A_HW;
               cmd.inp  = 4'(step_ff - 4'd1);
               cmd.addr = AW'(row_ff) * AW'(NI) + AW'(step_ff - 4'd1);
            end else begin
               cmd.act = msst_pkg::A_HSTORE;
            end
         end
         ST_OUT: begin
            cmd.cls    = 2'(row_ff);
            step_end   = 4'(NH + 1);
            row_end    = 3'(NC - 1);
            next_state = ST_EXP;
            advance    = 1'b1;
            if (step_ff == 4'd0) begin
               cmd.act  = msst_pkg::A_ZB;
               cmd.addr = AW'(msst_pkg::B2_BASE) + AW'(row_ff);
            end else if (step_ff <= 4'(NH)) begin
               cmd.act  = msst_pkg::A_ZW;
               cmd.hid  = 3'(step_ff - 4'd1);
               cmd.addr = AW'(msst_pkg::W2_BASE) + AW'(row_ff) * AW'(NH)
                          + AW'(step_ff - 4'd1);
            end else begin
               cmd.act = msst_pkg::A_ZSTORE;
            end
         end
         ST_EXP: begin
            cmd.cls    = 2'(row_ff);
            step_end   = 4'd1;
            row_end    = 3'(NC - 1);
            next_state = ST_DIV;
            advance    = 1'b1;
            cmd.act    = (step_ff == 4'd0) ? msst_pkg::A_EXP1 : msst_pkg::A_EXP2;
         end
         ST_DIV: begin
            cmd.cls    = 2'(row_ff);
            step_end   = 4'd2;
            row_end    = 3'(NC - 1);
            next_state = ST_RESULT;
            if (step_ff == 4'd0) begin
               cmd.act = msst_pkg::A_DSTART;
               advance = 1'b1;
            end else if (step_ff == 4'd1) begin
               advance = 1'b1;
            end else if (!stat.div_busy) begin
               cmd.act = msst_pkg::A_PSTORE;
               advance = 1'b1;
            end
         end
         ST_RESULT: begin
            cmd.act  = msst_pkg::A_OUT;
            state_in = train_ff ? ST_DZ : ST_IDLE;
         end
         ST_DZ: begin
            cmd.act  = msst_pkg::A_DZ;
            state_in = ST_DH;
         end
         ST_DH: begin
            // hidden gradient from the output weights before their update
            cmd.hid    = row_ff;
            step_end   = 4'(NC + 1);
            row_end    = 3'(NH - 1);
            next_state = ST_UPD2;
            advance    = 1'b1;
            if (step_ff == 4'd0) begin
               cmd.act = msst_pkg::A_DHCLR;
            end else if (step_ff <= 4'(NC)) begin
               cmd.act  = msst_pkg::A_DHW;
               cmd.cls  = 2'(step_ff - 4'd1);
               cmd.addr = AW'(msst_pkg::W2_BASE) + AW'(step_ff - 4'd1) * AW'(NH)
                          + AW'(row_ff);
            end else begin
               cmd.act = msst_pkg::A_DHSTORE;
            end
         end
         ST_UPD2: begin
            cmd.cls    = 2'(row_ff);
            step_end   = 4'(NH + 1);
            row_end    = 3'(NC - 1);
            next_state = ST_UPD1;
            advance    = 1'b1;
            if (step_ff == 4'd0) begin
               cmd.act = msst_pkg::A_G;
            end else if (step_ff == 4'd1) begin
               cmd.act  = msst_pkg::A_B2W;
               cmd.addr = AW'(msst_pkg::B2_BASE) + AW'(row_ff);
            end else begin
               cmd.act  = msst_pkg::A_W2W;
               cmd.hid  = 3'(step_ff - 4'd2);
               cmd.addr = AW'(msst_pkg::W2_BASE) + AW'(row_ff) * AW'(NH)
                          + AW'(step_ff - 4'd2);
            end
         end
         ST_UPD1: begin
            cmd.hid    = row_ff;
            step_end   = 4'(NI + 1);
            row_end    = 3'(NH - 1);
            next_state = ST_IDLE;
            advance    = 1'b1;
            if (step_ff == 4'd0) begin
               cmd.act = msst_pkg::A_S;
            end else if (step_ff == 4'd1) begin
               cmd.act  = msst_pkg::A_B1W;
               cmd.addr = AW'(msst_pkg::B1_BASE) + AW'(row_ff);
            end else begin
               cmd.act  = msst_pkg::A_W1W;
               cmd.inp  = 4'(step_ff - 4'd2);
               cmd.addr = AW'(row_ff) * AW'(NI) + AW'(step_ff - 4'd2);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (advance) begin
         if (step_ff == step_end) begin
            step_in = '0;
            if (row_ff == row_end) begin
               row_in   = '0;
               state_in = next_state;
            end else begin
               row_in = row_ff + 3'd1;
            end
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         row_ff   <= '0;
         train_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         row_ff   <= row_in;
         train_ff <= train_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/msst_dpath.sv =====
// ----------------------------------------------------------------------------
// msst_dpath
// weight store, accumulators, exponent, divider and update arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

module msst_dpath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire msst_pkg::cmd_type   cmd,
   output msst_pkg::stat_type       stat,
   input  wire logic [1:0]          req_op,
   input  wire logic [11:0]         req_features,
   input  wire logic [1:0]          req_label,
   input  wire logic [7:0]          req_weight_index,
   input  wire logic signed [15:0]  req_weight_value,
   input  wire logic                csr_write_enable,
   input  wire logic [15:0]         csr_write_data,
   output logic                     rsp_valid,
   output logic [15:0]              rsp_prob_class_zero,
   output logic [15:0]              rsp_prob_class_one,
   output logic [15:0]              rsp_prob_class_two,
   output logic [1:0]               rsp_best_class
);

   localparam int NI = msst_pkg::INPUT_COUNT;
   localparam int NH = msst_pkg::HIDDEN_COUNT;
   localparam int NC = msst_pkg::CLASS_COUNT;
   localparam int AW = msst_pkg::ADDR_W;
   localparam int WW = msst_pkg::WEIGHT_W;

   // request held for the whole item
   logic [1:0]    op_ff;
   logic [NI-1:0] feat_ff;
   logic [1:0]    label_ff;
   logic [7:0]    widx_ff;
   logic [WW-1:0] wval_ff;
   logic [msst_pkg::LR_W-1:0] lr_ff;

   // command delayed to line up with read data
   msst_pkg::act_type               act_ff;
   logic [AW-1:0]                   addr_ff;
   logic [msst_pkg::CLS_W-1:0]      cls_ff;
   logic [msst_pkg::HID_W-1:0]      hid_ff;
   logic [msst_pkg::INP_W-1:0]      inp_ff;

   logic signed [msst_pkg::HACC_W-1:0] hacc_ff;
   logic        [msst_pkg::H_W-1:0]    h_ff [NH];
   logic        [WW-1:0]               zbias_ff;
   logic signed [msst_pkg::OACC_W-1:0] oacc_ff;
   logic signed [msst_pkg::Z_W-1:0]    z_ff [NC];
   logic        [msst_pkg::T_W-1:0]    t_ff;
   logic        [msst_pkg::E_W-1:0]    e_ff [NC];
   logic        [msst_pkg::SUM_W-1:0]  sum_ff;
   logic        [msst_pkg::PROB_W-1:0] p_ff [NC];
   logic signed [msst_pkg::DZ_W-1:0]   dz_ff [NC];
   logic signed [msst_pkg::DACC_W-1:0] dacc_ff;
   logic signed [msst_pkg::DACC_W-1:0] dh_ff [NH];
   logic signed [msst_pkg::G_W-1:0]    g_ff;
   logic signed [msst_pkg::STEP_W-1:0] step_ff;

   logic        valid_ff;
   logic [15:0] prob0_ff, prob1_ff, prob2_ff;
   logic [1:0]  best_ff;

   logic [WW-1:0]              rd_data;
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [WW-1:0]              mem_wdata;
   logic                       div_start;
   logic [msst_pkg::NUM_W-1:0] div_numer;
   logic                       div_busy;
   logic [msst_pkg::Q_W-1:0]   div_quot;

   logic signed [msst_pkg::Z_W-1:0]  zmax;
   logic signed [msst_pkg::Z_W:0]    d_sig;
   logic [37:0]                      t_prod;
   logic [msst_pkg::E_W-1:0]         tab_a, tab_b, tab_diff, e_frac, e_val;
   logic [24:0]                      interp;
   logic [msst_pkg::PROB_W-1:0]      p_sat;
   logic [1:0]                       best;
   logic signed [msst_pkg::DZ_W-1:0] dz_in [NC];
   logic signed [31:0]               zw_prod;
   logic signed [33:0]               dhw_prod;
   logic signed [msst_pkg::G_W-1:0]  g_prod, g_rnd;
   logic signed [50:0]               gh_prod, gh_rnd;
   logic signed [52:0]               s_prod, s_rnd;
   logic signed [23:0]               rd_ext;
   logic [WW-1:0]                    b2_new, w2_new, w1_new;
   logic [msst_pkg::H_W-1:0]         h_clamp;

   msst_wmem u_wmem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (cmd.addr),
      .rdata (rd_data)
   );

   msst_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (sum_ff),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   assign stat.div_busy = div_busy;

   always_comb begin
      zmax = z_ff[0];
      for (int c = 1; c < NC; c++) begin
         if (z_ff[c] > zmax) begin
            zmax = z_ff[c];
         end
      end
      d_sig  = 25'(zmax) - 25'(z_ff[cls_ff]);
      t_prod = 38'(unsigned'(d_sig)) * 38'(msst_pkg::LOG2E_Q12);

      // table with linear interpolation, then the integer shift
      tab_a    = msst_pkg::exp2_entry({1'b0, t_ff[11:8]});
      tab_b    = msst_pkg::exp2_entry({1'b0, t_ff[11:8]} + 5'd1);
      tab_diff = tab_a - tab_b;
      interp   = 25'(tab_diff) * 25'(t_ff[7:0]);
      e_frac   = tab_a - 17'(interp >> 8);
      if (t_ff[msst_pkg::T_W-1:12] >= 14'd17) begin
         e_val = '0;
      end else begin
         e_val = e_frac >> t_ff[16:12];
      end

      div_start = (act_ff == msst_pkg::A_DSTART);
      div_numer = 34'({e_ff[cls_ff], 16'h0000}) + 34'(sum_ff >> 1);
      p_sat     = (div_quot > 17'd65535) ? 16'hffff : div_quot[15:0];

      best = '0;
      for (int c = 1; c < NC; c++) begin
         if (p_ff[c] > p_ff[best]) begin
            best = 2'(c);
         end
      end

      for (int c = 0; c < NC; c++) begin
         dz_in[c] = $signed({2'b00, p_ff[c]})
                    - ((label_ff == 2'(c)) ? 18'sd65536 : 18'sd0);
      end

      zw_prod  = $signed(rd_data) * $signed({1'b0, h_ff[hid_ff]});
      dhw_prod = $signed(rd_data) * dz_ff[cls_ff];
      g_prod   = $signed({1'b0, lr_ff}) * dz_ff[cls_ff];
      gh_prod  = g_ff * $signed({1'b0, h_ff[hid_ff]});
      s_prod   = $signed({1'b0, lr_ff}) * dh_ff[hid_ff];

      // half-up rounding of the step sizes
      g_rnd  = (g_ff + 35'sd524288) >>> 20;
      gh_rnd = (gh_prod + 51'sd2147483648) >>> 32;
      s_rnd  = (s_prod + 53'sd2147483648) >>> 32;

      rd_ext = 24'($signed(rd_data));
      b2_new = msst_pkg::sat16(rd_ext - g_rnd[23:0]);
      w2_new = msst_pkg::sat16(rd_ext - gh_rnd[23:0]);
      w1_new = msst_pkg::sat16(rd_ext - 24'(step_ff));

      if (hacc_ff < 0) begin
         h_clamp = '0;
      end else if (hacc_ff > 20'sd32767) begin
         h_clamp = 15'h7fff;
      end else begin
         h_clamp = hacc_ff[14:0];
      end

      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = w1_new;
      case (act_ff)
         msst_pkg::A_MISC: begin
            if ((op_ff == msst_pkg::OP_WRITE) && (widx_ff < 8'(msst_pkg::WEIGHT_DEPTH))) begin
               mem_we    = 1'b1;
               mem_waddr = widx_ff[AW-1:0];
               mem_wdata = wval_ff;
            end
         end
         msst_pkg::A_B2W: begin
            mem_we    = 1'b1;
            mem_wdata = b2_new;
         end
         msst_pkg::A_W2W: begin
            mem_we    = 1'b1;
            mem_wdata = w2_new;
         end
         msst_pkg::A_B1W: begin
            mem_we = 1'b1;
         end
         msst_pkg::A_W1W: begin
            mem_we = feat_ff[inp_ff];
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= msst_pkg::A_NOP;
         valid_ff <= 1'b0;
         lr_ff    <= msst_pkg::LR_RESET;
      end else begin
         act_ff   <= cmd.act;
         valid_ff <= (act_ff == msst_pkg::A_OUT) || (act_ff == msst_pkg::A_MISC);
         if (csr_write_enable) begin
            lr_ff <= csr_write_data;
         end
      end

      addr_ff <= cmd.addr;
      cls_ff  <= cmd.cls;
      hid_ff  <= cmd.hid;
      inp_ff  <= cmd.inp;

      if (cmd.load) begin
         op_ff    <= req_op;
         feat_ff  <= req_features;
         label_ff <= req_label;
         widx_ff  <= req_weight_index;
         wval_ff  <= req_weight_value;
      end

      case (act_ff)
         msst_pkg::A_HB:      hacc_ff <= 20'($signed(rd_data));
         msst_pkg::A_HW: begin
            if (feat_ff[inp_ff]) begin
               hacc_ff <= hacc_ff + 20'($signed(rd_data));
            end
         end
         msst_pkg::A_HSTORE:  h_ff[hid_ff] <= h_clamp;
         msst_pkg::A_ZB: begin
            zbias_ff <= rd_data;
            oacc_ff  <= '0;
         end
         msst_pkg::A_ZW:      oacc_ff <= oacc_ff + 35'(zw_prod);
         msst_pkg::A_ZSTORE:  z_ff[cls_ff] <= 24'($signed(zbias_ff)) + 24'(oacc_ff >>> 12);
         msst_pkg::A_EXP1:    t_ff <= t_prod[37:12];
         msst_pkg::A_EXP2: begin
            e_ff[cls_ff] <= e_val;
            sum_ff <= ((cls_ff == '0) ? '0 : sum_ff) + 18'(e_val);
         end
         msst_pkg::A_PSTORE:  p_ff[cls_ff] <= p_sat;
         msst_pkg::A_OUT: begin
            prob0_ff <= p_ff[0];
            prob1_ff <= p_ff[1];
            prob2_ff <= p_ff[2];
            best_ff  <= best;
         end
         msst_pkg::A_MISC: begin
            prob0_ff <= '0;
            prob1_ff <= '0;
            prob2_ff <= '0;
            best_ff  <= '0;
         end
         msst_pkg::A_DZ: begin
            for (int c = 0; c < NC; c++) begin
               dz_ff[c] <= dz_in[c];
            end
         end
         msst_pkg::A_DHCLR:   dacc_ff <= '0;
         msst_pkg::A_DHW:     dacc_ff <= dacc_ff + 36'(dhw_prod);
         msst_pkg::A_DHSTORE: dh_ff[hid_ff] <= (h_ff[hid_ff] != '0) ? dacc_ff : '0;
         msst_pkg::A_G:       g_ff <= g_prod;
         msst_pkg::A_S:       step_ff <= s_rnd[msst_pkg::STEP_W-1:0];
         default: begin
         end
      endcase
   end

   assign rsp_valid           = valid_ff;
   assign rsp_prob_class_zero = prob0_ff;
   assign rsp_prob_class_one  = prob1_ff;
   assign rsp_prob_class_two  = prob2_ff;
   assign rsp_best_class      = best_ff;

endmodule

`default_nettype wire

// ===== rtl/mlp_softmax_sgd_trainer.sv =====
// ----------------------------------------------------------------------------
// mlp_softmax_sgd_trainer
// 12-8-3 relu / softmax perceptron in fixed point with per-sample sgd training
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the sequencer has issued the last command of the item, and no new
// item is taken meanwhile. Each item gives exactly one result, shown on the
// rsp_ ports for a single cycle with rsp_valid high; the receiver cannot
// stall, so it must take the result in that cycle. A weight write or op three
// gives an all-zero result. Infer sweeps the hidden units, then the output
// classes, then the exponents, then the normalising divide for each class,
// and gives its probabilities. Train gives the same result at the same time
// and then stays busy for the gradient and update sweeps. The sweeps are
// paced by the weight store, read one entry a cycle, and by the bit-serial
// divider. Weights must be written before use; learning_rate may be written
// only while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mlp_softmax_sgd_trainer_defines.svh"

module mlp_softmax_sgd_trainer (
   input  wire logic                clock,
   input  wire logic                reset,
   // item request
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_op,
   input  wire logic [11:0]         req_features,
   input  wire logic [1:0]          req_label,
   input  wire logic [7:0]          req_weight_index,
   input  wire logic signed [15:0]  req_weight_value,
   // learning rate register
   input  wire logic                csr_write_enable,
   input  wire logic [15:0]         csr_write_data,
   // result
   output logic                     rsp_valid,
   output logic [15:0]              rsp_prob_class_zero,
   output logic [15:0]              rsp_prob_class_one,
   output logic [15:0]              rsp_prob_class_two,
   output logic [1:0]               rsp_best_class
);

   msst_pkg::cmd_type  cmd;
   msst_pkg::stat_type stat;

   // sequencer issues one command a cycle
   msst_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .stat   (stat),
      .busy   (busy),
      .cmd    (cmd)
   );

   // datapath runs each command in the cycle after it is issued, with the read data
   msst_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_op              (req_op),
      .req_features        (req_features),
      .req_label           (req_label),
      .req_weight_index    (req_weight_index),
      .req_weight_value    (req_weight_value),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_prob_class_zero (rsp_prob_class_zero),
      .rsp_prob_class_one  (rsp_prob_class_one),
      .rsp_prob_class_two  (rsp_prob_class_two),
      .rsp_best_class      (rsp_best_class)
   );

   // one strobe per item, never two in a row
   `MSST_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid, "result strobe held")
   // an accepted item always holds the block busy
   `MSST_ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy, "not busy after accept")
   // winning class is a real class
   `MSST_ASSERT_SAME(a_best_class, clock, reset, rsp_valid, rsp_best_class != 2'd3, "bad best class")

endmodule

`default_nettype wire
